// ===== rtl/bet_pkg.sv =====
package bet_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;

  localparam logic CfgUpper = 1'b0;
  localparam logic CfgBins  = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        point_freq;
    logic signed [15:0] point_mag;
    logic [11:0]        bin_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] magnitude;
    logic               covered;
    logic               table_full;
    logic [4:0]         point_count;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/bet_div.sv =====
module bet_div (
  input  logic              clk,
  input  logic              rst,
  input  bet_pkg::div_req_t req,
  output logic              done,
  output logic [47:0]       quot
);
  import bet_pkg::*;

  logic [47:0] q;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[47]} - {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q    <= req.dividend;
        rem  <= '0;
        cnt  <= 6'd47;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[47]};
          q   <= {q[46:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  assign quot = q;
endmodule

// ===== rtl/breakpoint_envelope_table.sv =====
// Breakpoint envelope table: a frequency-sorted list of up to MaxPoints
// control points, queried one bin at a time for a piecewise-linear value.
// Input channel (in_valid/in_stall, in_data) carries clear, insert and query
// commands; each accepted command returns exactly one result on the output
// channel (out_valid/out_stall, out_data). One command is worked at a time.
// Insert walks the table once to find the slot and then shifts entries
// one by one through the point memory, a read and a write each. A query
// walks every segment, two memory reads per point, and runs two 48-step
// serial divisions per segment for the bin bounds plus one for the
// interpolation where the segment covers the bin.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while
// idle; the block itself does not enforce this.
// Reset (rst, synchronous) empties the table and loads upper_freq 5500 and
// bin_count 1024; memory contents stay undefined until written.
// When the receiver stalls, the result holds in the output register and the
// block takes no new command until it is transferred.
module breakpoint_envelope_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bet_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bet_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);
  import bet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
    S_Q_RD, S_Q_LO, S_Q_LOW, S_Q_HI, S_Q_HIW, S_Q_INT, S_Q_INTW, S_OUT
  } state_t;

  logic [31:0] mem [MaxPoints];
  logic [31:0] rd_data;
  logic [IdxW-1:0] rd_addr;

  state_t state;
  in_item_t cur;
  logic [15:0] upper_freq;
  logic [12:0] bin_count;
  logic [CntW-1:0] count;
  logic [CntW-1:0] pos;
  logic [CntW-1:0] k;
  logic [15:0] fb;
  logic signed [15:0] ma, mb;
  logic [47:0] lo, hi;
  logic signed [15:0] val;
  logic hit;

  div_req_t dreq;
  logic ddone;
  logic [47:0] dq;

  logic [15:0] up;
  logic signed [17:0] dm;
  logic [12:0] boff;
  logic [31:0] span;
  logic signed [31:0] num;
  logic [31:0] num_abs;
  logic [47:0] qs;
  logic signed [16:0] vsum;

  bet_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dq));

  assign up = (upper_freq == 16'd0) ? 16'd1 : upper_freq;
  assign dm = 18'(mb) - 18'(ma);
  assign boff = 13'(cur.bin_index) - lo[12:0];
  assign span = 32'(hi - lo);
  assign num = 32'(dm) * $signed({19'd0, boff});
  assign num_abs = num[31] ? 32'(-num) : 32'(num);
  assign qs = num[31] ? 48'(-dq) : dq;
  assign vsum = 17'(ma) + 17'($signed(qs[16:0]));

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      upper_freq <= 16'd5500;
      bin_count  <= 13'd1024;
      dreq       <= '0;
    end else begin
      dreq.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CfgUpper) upper_freq <= cfg_data;
        else bin_count <= cfg_data[12:0];
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cur <= in_data;
            out_data <= '0;
            hit <= 1'b0;
            val <= '0;
            pos <= '0;
            k   <= '0;
            rd_addr <= '0;
            unique case (in_data.cmd)
              CmdClear: begin
                count <= '0;
                state <= S_OUT;
              end
              CmdInsert: begin
                if (count == CntW'(MaxPoints)) begin
                  out_data.table_full <= 1'b1;
                  state <= S_OUT;
                end else state <= S_FIND_RD;
              end
              CmdQuery: begin
                if ({1'b0, in_data.bin_index} >= bin_count || count == '0)
                  state <= S_OUT;
                else state <= S_Q_RD;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_FIND_RD: begin
          if (pos == count) state <= S_PUT;
          else state <= S_FIND;
        end
        S_FIND: begin
          if (cur.point_freq > rd_data[31:16]) begin
            pos <= pos + 1'b1;
            rd_addr <= IdxW'(pos + 1'b1);
            state <= S_FIND_RD;
          end else begin
            k <= count;
            rd_addr <= IdxW'(count - 1'b1);
            state <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          if (k == pos) state <= S_PUT;
          else state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          mem[IdxW'(k)] <= rd_data;
          k <= k - 1'b1;
          rd_addr <= IdxW'(k - 2'd2);
          state <= S_SHIFT_RD;
        end
        S_PUT: begin
          mem[IdxW'(pos)] <= {cur.point_freq, cur.point_mag};
          count <= count + 1'b1;
          out_data.point_count <= 5'(count + 1'b1);
          state <= S_OUT;
        end
        S_Q_RD: begin
          rd_addr <= IdxW'(k + 1'b1);
          state <= S_Q_LO;
        end
        S_Q_LO: begin
          ma <= rd_data[15:0];
          dreq.start <= 1'b1;
          dreq.dividend <= 48'(32'(rd_data[31:16]) * 32'(bin_count));
          dreq.divisor <= 32'(up);
          state <= S_Q_LOW;
        end
        S_Q_LOW: begin
          if (k + 1'b1 < count) begin
            fb <= rd_data[31:16];
            mb <= rd_data[15:0];
          end else begin
            fb <= up;
            mb <= '0;
          end
          if (ddone) begin
            lo <= dq;
            state <= S_Q_HI;
          end
        end
        S_Q_HI: begin
          dreq.start <= 1'b1;
          dreq.dividend <= 48'(32'(fb) * 32'(bin_count));
          dreq.divisor <= 32'(up);
          state <= S_Q_HIW;
        end
        S_Q_HIW: begin
          if (ddone) begin
            hi <= dq;
            state <= S_Q_INT;
          end
        end
        S_Q_INT: begin
          if (48'(cur.bin_index) >= lo && 48'(cur.bin_index) < hi) begin
            dreq.start <= 1'b1;
            dreq.dividend <= 48'(num_abs);
            dreq.divisor <= span;
            state <= S_Q_INTW;
          end else if (k + 1'b1 < count) begin
            k <= k + 1'b1;
            rd_addr <= IdxW'(k + 1'b1);
            state <= S_Q_RD;
          end else begin
            out_data.magnitude <= hit ? val : '0;
            out_data.covered <= hit;
            state <= S_OUT;
          end
        end
        S_Q_INTW: begin
          if (ddone) begin
            hit <= 1'b1;
            val <= vsum[15:0];
            if (k + 1'b1 < count) begin
              k <= k + 1'b1;
              rd_addr <= IdxW'(k + 1'b1);
              state <= S_Q_RD;
            end else begin
              out_data.magnitude <= vsum[15:0];
              out_data.covered <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (cur.cmd != CmdInsert) out_data.point_count <= 5'(count);
          else if (out_data.table_full) out_data.point_count <= 5'(count);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxPoints))
    else $error("point count beyond table depth");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bet_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CfgUpper;
  logic [15:0] cfg_data = '0;

  breakpoint_envelope_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // table copy and settings
  logic [15:0] tbl_freq [MaxPoints];
  int tbl_mag [MaxPoints];
  int tbl_count = 0;
  int cfg_upper = 5500;
  int cfg_bins = 1024;

  in_item_t cmd_q[$];
  out_item_t want_q[$];
  int errors = 0;
  bit steady_send = 0;
  bit steady_recv = 0;

  function automatic longint bin_edge(longint f, longint up);
    return (f * cfg_bins) / up;
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t r;
    longint up, lo, hi, fa, fb, ma, mb, b, v;
    int pos;
    r = '0;
    if (it.cmd == CmdClear) begin
      tbl_count = 0;
    end else if (it.cmd == CmdInsert) begin
      if (tbl_count >= MaxPoints) begin
        r.table_full = 1'b1;
      end else begin
        pos = 0;
        while (pos < tbl_count && it.point_freq > tbl_freq[pos]) pos++;
        for (int k = tbl_count; k > pos; k--) begin
          tbl_freq[k] = tbl_freq[k-1];
          tbl_mag[k] = tbl_mag[k-1];
        end
        tbl_freq[pos] = it.point_freq;
        tbl_mag[pos] = it.point_mag;
        tbl_count++;
      end
    end else if (it.cmd == CmdQuery) begin
      up = (cfg_upper == 0) ? 1 : cfg_upper;
      b = it.bin_index;
      if (b < cfg_bins) begin
        for (int i = 0; i < tbl_count; i++) begin
          fa = tbl_freq[i];
          ma = tbl_mag[i];
          fb = (i + 1 < tbl_count) ? longint'(tbl_freq[i+1]) : up;
          mb = (i + 1 < tbl_count) ? longint'(tbl_mag[i+1]) : 0;
          lo = bin_edge(fa, up);
          hi = bin_edge(fb, up);
          if (b >= lo && b < hi) begin
            v = ma + ((mb - ma) * (b - lo)) / (hi - lo);
            r.magnitude = v[15:0];
            r.covered = 1'b1;
          end
        end
      end
    end
    r.point_count = tbl_count[4:0];
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        want_q.push_back(apply_command(in_data));
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (in_valid && !in_stall) begin
        if (!steady_send && $urandom_range(0, 9) != 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 9);
        end else if (cmd_q.size() > 0) begin
          in_data <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (cmd_q.size() > 0) begin
        in_data <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    out_item_t w;
    int nxt;
    nxt = recv_gap;
    if (!rst && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        $error("transfer with no expected result");
        errors++;
      end else begin
        w = want_q.pop_front();
        if (out_data.magnitude !== w.magnitude) begin
          $error("magnitude exp %0d got %0d", w.magnitude, out_data.magnitude);
          errors++;
        end
        if (out_data.covered !== w.covered) begin
          $error("covered exp %0d got %0d", w.covered, out_data.covered);
          errors++;
        end
        if (out_data.table_full !== w.table_full) begin
          $error("table_full exp %0d got %0d", w.table_full, out_data.table_full);
          errors++;
        end
        if (out_data.point_count !== w.point_count) begin
          $error("point_count exp %0d got %0d", w.point_count, out_data.point_count);
          errors++;
        end
      end
      nxt = steady_recv ? 0 : $urandom_range(0, 9);
    end else if (nxt > 0) begin
      nxt = nxt - 1;
    end
    recv_gap <= nxt;
    out_stall <= !rst && (nxt != 0);
  end

  function automatic in_item_t make_cmd(logic [1:0] c, int f, int m, int b);
    in_item_t it;
    it.cmd = c;
    it.point_freq = f[15:0];
    it.point_mag = m[15:0];
    it.bin_index = b[11:0];
    return it;
  endfunction

  function automatic int pick_freq();
    int lim;
    lim = cfg_upper + cfg_upper / 8 + 1;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 65535);
    return (lim > 65535) ? $urandom_range(0, 65535) : $urandom_range(0, lim);
  endfunction

  function automatic int pick_bin();
    if ($urandom_range(0, 9) == 0 || cfg_bins == 0) return $urandom_range(0, 4095);
    return (cfg_bins > 4095) ? $urandom_range(0, 4095) : $urandom_range(0, cfg_bins);
  endfunction

  task automatic fill_random(int n);
    int npts;
    while (n > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        cmd_q.push_back(make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 4095)));
        n--;
      end else begin
        cmd_q.push_back(make_cmd(CmdClear, 0, 0, 0));
        npts = ($urandom_range(0, 7) == 0) ? 18 : $urandom_range(1, 6);
        for (int i = 0; i < npts; i++)
          cmd_q.push_back(make_cmd(CmdInsert, pick_freq(), $urandom_range(0, 65535),
                                   $urandom_range(0, 4095)));
        for (int i = 0; i < 8; i++)
          cmd_q.push_back(make_cmd(CmdQuery, $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), pick_bin()));
        n -= npts + 9;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() > 0 || in_valid || want_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgUpper) cfg_upper = v & 16'hFFFF;
    else cfg_bins = v & 16'h1FFF;
    @(posedge clk);
  endtask

  int uppers [6] = '{5500, 1, 65535, 0, 3000, 800};
  int binss [6] = '{1024, 1, 4096, 0, 4096, 37};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    cmd_q.push_back(make_cmd(CmdQuery, 0, 0, 0));
    cmd_q.push_back(make_cmd(CmdInsert, 0, 32767, 4095));
    cmd_q.push_back(make_cmd(CmdInsert, 65535, -32768, 0));
    cmd_q.push_back(make_cmd(CmdInsert, 2750, -32768, 0));
    cmd_q.push_back(make_cmd(CmdInsert, 2750, 32767, 0));
    cmd_q.push_back(make_cmd(CmdQuery, 0, 0, 0));
    cmd_q.push_back(make_cmd(CmdQuery, 0, 0, 511));
    cmd_q.push_back(make_cmd(CmdQuery, 0, 0, 1023));
    cmd_q.push_back(make_cmd(CmdQuery, 65535, -1, 1024));
    cmd_q.push_back(make_cmd(CmdQuery, 0, 0, 4095));
    cmd_q.push_back(make_cmd(2'd3, 65535, -1, 4095));
    for (int i = 0; i < 13; i++)
      cmd_q.push_back(make_cmd(CmdInsert, 400 * i, 1000 * i - 6000, 0));
    cmd_q.push_back(make_cmd(CmdQuery, 0, 0, 700));
    cmd_q.push_back(make_cmd(CmdClear, 65535, -1, 4095));
    cmd_q.push_back(make_cmd(CmdQuery, 0, 0, 10));
    fill_random(300);
    drain();

    for (int p = 1; p < 6; p++) begin
      write_reg(CfgUpper, uppers[p]);
      write_reg(CfgBins, binss[p]);
      fill_random(320);
      drain();
    end

    steady_send = 1;
    steady_recv = 1;
    write_reg(CfgUpper, 5500);
    write_reg(CfgBins, 1024);
    fill_random(60);
    drain();

    if (errors == 0) begin
      $display("breakpoint_envelope_table test passed");
    end else begin
      $display("breakpoint_envelope_table test failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("breakpoint_envelope_table test failed");
    $finish;
  end

endmodule

// ===== breakpoint_envelope_table.f =====
rtl/bet_pkg.sv
rtl/bet_div.sv
rtl/breakpoint_envelope_table.sv
verif/testbench.sv
